// ===== hw/rtl/bsb_pkg.sv =====
// Shared constants and types of the spectrum bar ballistics unit.
`default_nettype none

package bsb_pkg;

   // Field widths.
   localparam int BIN_W   = 8;
   localparam int MAG_W   = 16;
   localparam int LEVEL_W = 16;
   localparam int HOLD_W  = 10;
   localparam int COEF_W  = 16;
   localparam int PROD_W  = 32;

   // Wide enough to compare a bin index against the largest bin count.
   localparam int BIN_CMP_W = 13;

   // Default number of bins.
   localparam int NUM_BINS_DEF = 256;

   // Full-scale level in Q0.16.
   localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'hFFFF;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_COEF  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COEF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_FRAMES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP   = 3'd4;

   // Register values after reset.
   localparam logic [COEF_W-1:0] GAIN_RST         = 16'd256;
   localparam logic [COEF_W-1:0] ATTACK_COEF_RST  = 16'd53150;
   localparam logic [COEF_W-1:0] RELEASE_COEF_RST = 16'd10070;
   localparam logic [HOLD_W-1:0] HOLD_FRAMES_RST  = 10'd30;
   localparam logic [COEF_W-1:0] DECAY_STEP_RST   = 16'd328;

   // Result queue: depth is a power of two so the pointers wrap naturally.
   // The count width also covers the fill level plus the items in the pipeline (at most 3).
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;
   localparam logic [FIFO_CNT_W-1:0] FIFO_DEPTH_V = 4'd8;

   // One result item.
   typedef struct packed {
      logic [BIN_W-1:0]   bin_out;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] peak;
   } rsp_item_type;

   // Stored state of one bin.
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] peak;
      logic [HOLD_W-1:0]  hold;
   } bin_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bsb_if.sv =====
// Valid/ready channel interfaces for the bin input and the result output.
`default_nettype none

interface bsb_req_if;
   logic                        valid;
   logic                        ready;
   logic [bsb_pkg::BIN_W-1:0]   bin_index;
   logic [bsb_pkg::MAG_W-1:0]   magnitude;

   modport source (output valid, bin_index, magnitude, input ready);
   modport sink   (input valid, bin_index, magnitude, output ready);
endinterface

interface bsb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bsb_pkg::BIN_W-1:0]   bin_out;
   logic [bsb_pkg::LEVEL_W-1:0] level;
   logic [bsb_pkg::LEVEL_W-1:0] peak;

   modport source (output valid, bin_out, level, peak, input ready);
   modport sink   (input valid, bin_out, level, peak, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bsb_fifo.sv =====
// Result queue between the update pipeline and the result channel.
`default_nettype none

module bsb_fifo (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire bsb_pkg::rsp_item_type            push_data,
   input  wire logic                             pop,
   output logic                                  out_valid,
   output bsb_pkg::rsp_item_type                 out_data,
   output logic [bsb_pkg::FIFO_CNT_W-1:0]        count
);

   bsb_pkg::rsp_item_type                  entries_ff [bsb_pkg::FIFO_DEPTH];
   logic [bsb_pkg::FIFO_PTR_W-1:0]         wr_ptr_ff;
   logic [bsb_pkg::FIFO_PTR_W-1:0]         rd_ptr_ff;
   logic [bsb_pkg::FIFO_CNT_W-1:0]         count_ff;
   logic [bsb_pkg::FIFO_CNT_W-1:0]         count_in;

   // Storage; entries need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Next fill level.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < bsb_pkg::FIFO_DEPTH_V || pop))
      else $error("result queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("result queue read while empty");

   a_push_shows : assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == '0) |=> out_valid)
      else $error("pushed result not presented");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/spectrum_bar_ballistics_unit.sv =====
// Top level of the spectrum bar ballistics unit: per-bin level and peak update pipeline.
//
// Usage: each transfer on req_ch carries one spectrum bin (index and Q4.12 magnitude).
// For every transfer exactly one result leaves on rsp_ch, in order: the bin index,
// the smoothed bar level and the peak marker, both Q0.16. Bins at or above NUM_BINS
// change no state and return level and peak as zero.
// Registers are written through csr_we / csr_index / csr_wdata; the user must write them
// only while no item is in flight, and the block itself does not enforce this.
// Path: a result passes three pipeline stages and enters the queue before it is presented.
// Throughput: one item per cycle while req_ch.ready is high, also for the same bin in
// consecutive cycles, since the per-bin state is forwarded between stages.
// The level update (subtract, multiply, add or subtract) is the loop that sets this rate.
// Reset: synchronous; the registers take their default values and a clearing pass
// writes zero to every bin entry, one per cycle; req_ch.ready stays low during that pass.
// Stall: results wait in an 8-entry queue. Input is taken as long as the queue has
// room for every item in flight, so req_ch.ready falls only once the receiver has
// held off long enough to fill it.
`default_nettype none

module spectrum_bar_ballistics_unit #(
   parameter int NUM_BINS = bsb_pkg::NUM_BINS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   bsb_req_if.sink                                 req_ch,
   bsb_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_we,
   input  wire logic [bsb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bsb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int CMP_W  = bsb_pkg::BIN_CMP_W;
   localparam int LW     = bsb_pkg::LEVEL_W;
   localparam int HW     = bsb_pkg::HOLD_W;
   localparam int CNT_W  = bsb_pkg::FIFO_CNT_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NUM_BINS - 1);
   localparam logic [CMP_W-1:0]  NUM_BINS_V = CMP_W'(NUM_BINS);

   // Configuration registers.
   logic [bsb_pkg::COEF_W-1:0] gain_ff;
   logic [bsb_pkg::COEF_W-1:0] attack_ff;
   logic [bsb_pkg::COEF_W-1:0] release_ff;
   logic [HW-1:0]              hold_frames_ff;
   logic [bsb_pkg::COEF_W-1:0] decay_ff;

   // Clearing pass.
   logic              clr_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // Bin state memory.
   bsb_pkg::bin_state_type mem [NUM_BINS];
   bsb_pkg::bin_state_type rd_ff;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   bsb_pkg::bin_state_type mem_wdata;

   // Input transfer.
   logic                   accept;
   logic [ADDR_W-1:0]      req_addr;
   logic                   req_ok;

   // Stage 1: memory read and gain product.
   logic                        v1_ff;
   logic [bsb_pkg::BIN_W-1:0]   bin1_ff;
   logic [bsb_pkg::MAG_W-1:0]   mag1_ff;
   logic                        ok1_ff;
   logic [ADDR_W-1:0]           addr1_ff;
   bsb_pkg::bin_state_type      st1;

   // Stage 2: level update.
   logic                        v2_ff;
   logic [bsb_pkg::BIN_W-1:0]   bin2_ff;
   logic                        ok2_ff;
   logic [ADDR_W-1:0]           addr2_ff;
   logic [bsb_pkg::PROD_W-1:0]  prod2_ff;
   bsb_pkg::bin_state_type      st2_ff;
   logic [LW-1:0]               target;
   logic [LW-1:0]               lvl_old;
   logic                        rising;
   logic [LW-1:0]               diff;
   logic [bsb_pkg::COEF_W-1:0]  coef;
   logic [bsb_pkg::PROD_W-1:0]  smooth_prod;
   logic [LW-1:0]               lvl_new;

   // Stage 3: peak and hold update.
   logic                        v3_ff;
   logic [bsb_pkg::BIN_W-1:0]   bin3_ff;
   logic                        ok3_ff;
   logic [ADDR_W-1:0]           addr3_ff;
   logic [LW-1:0]               level3_ff;
   logic [LW-1:0]               peak3_ff;
   logic [HW-1:0]               hold3_ff;
   logic                        fwd3;
   logic [LW-1:0]               pk_old;
   logic [HW-1:0]               hold_old;
   logic [LW-1:0]               pk_new;
   logic [HW-1:0]               hold_new;
   logic [LW:0]                 decay_floor;
   logic                        item_we;
   bsb_pkg::bin_state_type      item_wdata;

   // Last item write, registered for forwarding.
   logic                        wr_v_ff;
   logic [ADDR_W-1:0]           wr_addr_ff;
   bsb_pkg::bin_state_type      wr_data_ff;

   // Result queue.
   bsb_pkg::rsp_item_type       push_data;
   bsb_pkg::rsp_item_type       out_data;
   logic                        out_valid;
   logic                        pop;
   logic [CNT_W-1:0]            fifo_count;
   logic [CNT_W-1:0]            occupancy;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff        <= bsb_pkg::GAIN_RST;
         attack_ff      <= bsb_pkg::ATTACK_COEF_RST;
         release_ff     <= bsb_pkg::RELEASE_COEF_RST;
         hold_frames_ff <= bsb_pkg::HOLD_FRAMES_RST;
         decay_ff       <= bsb_pkg::DECAY_STEP_RST;
      end else if (csr_we) begin
         case (csr_index)
            bsb_pkg::CSR_GAIN:         gain_ff        <= csr_wdata;
            bsb_pkg::CSR_ATTACK_COEF:  attack_ff      <= csr_wdata;
            bsb_pkg::CSR_RELEASE_COEF: release_ff     <= csr_wdata;
            bsb_pkg::CSR_HOLD_FRAMES:  hold_frames_ff <= csr_wdata[HW-1:0];
            bsb_pkg::CSR_DECAY_STEP:   decay_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clearing pass over all bins after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // Input side: take an item while the queue has room for everything in flight.
   assign occupancy = fifo_count + CNT_W'(v1_ff) + CNT_W'(v2_ff) + CNT_W'(v3_ff);
   assign req_ch.ready = !clr_ff && (occupancy < bsb_pkg::FIFO_DEPTH_V);
   assign accept   = req_ch.valid && req_ch.ready;
   assign req_addr = ADDR_W'(req_ch.bin_index);
   assign req_ok   = CMP_W'(req_ch.bin_index) < NUM_BINS_V;

   // Memory write port: clearing pass or item write-back.
   assign mem_we    = clr_ff || item_we;
   assign mem_waddr = clr_ff ? clr_addr_ff : addr3_ff;
   assign mem_wdata = clr_ff ? '0 : item_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[req_addr];
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         wr_v_ff <= 1'b0;
      end else begin
         v1_ff   <= accept;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         wr_v_ff <= item_we;
      end
   end

   // Stage 1: fold in the writes the memory read did not see.
   always_comb begin
      if (item_we && addr3_ff == addr1_ff) begin
         st1 = item_wdata;
      end else if (wr_v_ff && wr_addr_ff == addr1_ff) begin
         st1 = wr_data_ff;
      end else begin
         st1 = rd_ff;
      end
   end

   // Stage 2: target from the gain product, then move the level toward it.
   always_comb begin
      target = (prod2_ff[bsb_pkg::PROD_W-1:LW+4] != '0) ? bsb_pkg::FULL_SCALE
                                                       : prod2_ff[LW+3:4];
      if (v3_ff && ok3_ff && addr3_ff == addr2_ff) begin
         lvl_old = level3_ff;
      end else begin
         lvl_old = st2_ff.level;
      end
      rising      = target > lvl_old;
      diff        = rising ? (target - lvl_old) : (lvl_old - target);
      coef        = rising ? attack_ff : release_ff;
      smooth_prod = {16'b0, diff} * {16'b0, coef};
      lvl_new     = rising ? (lvl_old + smooth_prod[bsb_pkg::PROD_W-1:LW])
                           : (lvl_old - smooth_prod[bsb_pkg::PROD_W-1:LW]);
   end

   // Stage 3: peak follows the level, then holds, then decays.
   always_comb begin
      fwd3        = wr_v_ff && wr_addr_ff == addr3_ff;
      pk_old      = fwd3 ? wr_data_ff.peak : peak3_ff;
      hold_old    = fwd3 ? wr_data_ff.hold : hold3_ff;
      decay_floor = {1'b0, level3_ff} + {1'b0, decay_ff};
      pk_new      = pk_old;
      hold_new    = hold_old;
      if (level3_ff >= pk_old) begin
         pk_new   = level3_ff;
         hold_new = hold_frames_ff;
      end else if (hold_old != '0) begin
         hold_new = hold_old - 1'b1;
      end else if ({1'b0, pk_old} > decay_floor) begin
         pk_new = pk_old - decay_ff;
      end else begin
         pk_new = level3_ff;
      end
   end

   assign item_we          = v3_ff && ok3_ff;
   assign item_wdata.level = level3_ff;
   assign item_wdata.peak  = pk_new;
   assign item_wdata.hold  = hold_new;

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      bin1_ff    <= req_ch.bin_index;
      mag1_ff    <= req_ch.magnitude;
      ok1_ff     <= req_ok;
      addr1_ff   <= req_addr;

      bin2_ff    <= bin1_ff;
      ok2_ff     <= ok1_ff;
      addr2_ff   <= addr1_ff;
      prod2_ff   <= {16'b0, mag1_ff} * {16'b0, gain_ff};
      st2_ff     <= st1;

      bin3_ff    <= bin2_ff;
      ok3_ff     <= ok2_ff;
      addr3_ff   <= addr2_ff;
      level3_ff  <= lvl_new;
      peak3_ff   <= st2_ff.peak;
      hold3_ff   <= st2_ff.hold;

      wr_addr_ff <= addr3_ff;
      wr_data_ff <= item_wdata;
   end

   // Results of out-of-range bins read as zero.
   assign push_data.bin_out = bin3_ff;
   assign push_data.level   = ok3_ff ? level3_ff : '0;
   assign push_data.peak    = ok3_ff ? pk_new : '0;

   assign pop = out_valid && rsp_ch.ready;

   bsb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (v3_ff),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (out_valid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_ch.valid   = out_valid;
   assign rsp_ch.bin_out = out_data.bin_out;
   assign rsp_ch.level   = out_data.level;
   assign rsp_ch.peak    = out_data.peak;

`ifndef SYNTHESIS
   a_room_for_flight : assert property (@(posedge clock) disable iff (reset)
      occupancy <= bsb_pkg::FIFO_DEPTH_V)
      else $error("items in flight exceed result queue room");

   a_clear_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(clr_ff && (v1_ff || v2_ff || v3_ff)))
      else $error("item in pipeline during clearing pass");

   a_stage_order : assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(v2_ff))
      else $error("stage 3 valid without stage 2 item");

   a_clear_complete : assert property (@(posedge clock) disable iff (reset)
      $fell(clr_ff) |-> ($past(clr_addr_ff) == LAST_ADDR))
      else $error("clearing pass ended early");
`endif

endmodule

`default_nettype wire
